// ===== rtl/combined_lcg_shuffle_rng_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the combined LCG shuffle RNG
// Each macro expands to one labeled concurrent assertion. The assertion is
// clocked on clk and is disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef COMBINED_LCG_SHUFFLE_RNG_UNIT_ASSERT_SVH
`define COMBINED_LCG_SHUFFLE_RNG_UNIT_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define CLSR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define CLSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/clsr_pkg.sv =====
// ---------------------------------------------------------------------------
// clsr_pkg
// Types, constants and the microcode program of the combined LCG shuffle RNG.
// ---------------------------------------------------------------------------
`default_nettype none

package clsr_pkg;

  // Generator constants (Schrage factorization: mod = mul * quo + rem)
  localparam logic [30:0] MOD_A  = 31'd2147483563;
  localparam logic [30:0] MOD_B  = 31'd2147483399;
  localparam logic [30:0] INIT_B = 31'd123456789;

  // Extra warm-up steps on a reseed beyond the table depth
  localparam int WARMUP_EXTRA = 8;

  // Reciprocals of the Schrage quotients, scaled by 2^47
  localparam logic [31:0] RECIP_A = 32'((64'd1 << 47) / 64'd53668);
  localparam logic [31:0] RECIP_B = 32'((64'd1 << 47) / 64'd52774);

  typedef struct packed {
    logic [30:0] modulus;
    logic [15:0] mul;
    logic [15:0] quo;
    logic [13:0] rem;
    logic [31:0] recip;
    logic [30:0] init;
  } lane_cst_t;

  localparam lane_cst_t LANE_A_CST = '{
    modulus: MOD_A, mul: 16'd40014, quo: 16'd53668, rem: 14'd12211,
    recip: RECIP_A, init: 31'd0
  };
  localparam lane_cst_t LANE_B_CST = '{
    modulus: MOD_B, mul: 16'd40692, quo: 16'd52774, rem: 14'd3791,
    recip: RECIP_B, init: INIT_B
  };

  // Lane datapath operations, one Schrage phase each
  typedef enum logic [2:0] {
    LOP_NONE,
    LOP_RECIP,  // p = z * recip
    LOP_KQ,     // k = p >> 47, p = k * quo
    LOP_FIX,    // r = z - p, correct k and r by one quotient
    LOP_MR,     // p = mul * r
    LOP_KR,     // q = k * rem
    LOP_FIN     // z = p - q, wrap by the modulus when negative
  } lop_t;

  typedef enum logic [1:0] {
    JMP_NEXT,   // advance to the following step
    JMP_CMD,    // reseed goes to target, next goes to the output sequence
    JMP_LOOP,   // warm-up counter nonzero: count down and go to target
    JMP_END     // release the sequencer
  } jmp_t;

  typedef logic [3:0] upc_t;

  localparam upc_t UPC_DISPATCH = 4'd0;
  localparam upc_t UPC_W_RECIP  = 4'd1;
  localparam upc_t UPC_W_KQ     = 4'd2;
  localparam upc_t UPC_W_FIX    = 4'd3;
  localparam upc_t UPC_W_MR     = 4'd4;
  localparam upc_t UPC_W_KR     = 4'd5;
  localparam upc_t UPC_W_FIN    = 4'd6;
  localparam upc_t UPC_W_STORE  = 4'd7;
  localparam upc_t UPC_S_RECIP  = 4'd8;
  localparam upc_t UPC_S_KQ     = 4'd9;
  localparam upc_t UPC_S_FIX    = 4'd10;
  localparam upc_t UPC_S_MR     = 4'd11;
  localparam upc_t UPC_S_KR     = 4'd12;
  localparam upc_t UPC_S_FIN    = 4'd13;
  localparam upc_t UPC_EMIT     = 4'd14;

  // One control word of the program
  typedef struct packed {
    lop_t op;
    logic b_en;
    logic seed_ld;
    logic warm_wr;
    logic slot_est;
    logic slot_rd;
    logic emit;
    jmp_t jmp;
    upc_t target;
  } ucw_t;

  // Control from the sequencer to the datapath
  typedef struct packed {
    lop_t a_op;
    lop_t b_op;
    logic seed_ld;
    logic warm_wr;
    logic slot_est;
    logic slot_rd;
    logic emit;
  } ctl_t;

  function automatic ucw_t clsr_ucode(input upc_t pc);
    ucw_t w;
    w = '{op: LOP_NONE, b_en: 1'b0, seed_ld: 1'b0, warm_wr: 1'b0,
          slot_est: 1'b0, slot_rd: 1'b0, emit: 1'b0, jmp: JMP_NEXT,
          target: UPC_W_RECIP};
    case (pc)
      UPC_DISPATCH: begin
        w.seed_ld = 1'b1;
        w.jmp     = JMP_CMD;
        w.target  = UPC_W_RECIP;
      end
      UPC_W_RECIP: w.op = LOP_RECIP;
      UPC_W_KQ:    w.op = LOP_KQ;
      UPC_W_FIX:   w.op = LOP_FIX;
      UPC_W_MR:    w.op = LOP_MR;
      UPC_W_KR:    w.op = LOP_KR;
      UPC_W_FIN:   w.op = LOP_FIN;
      UPC_W_STORE: begin
        w.warm_wr = 1'b1;
        w.jmp     = JMP_LOOP;
        w.target  = UPC_W_RECIP;
      end
      UPC_S_RECIP: begin
        w.op       = LOP_RECIP;
        w.b_en     = 1'b1;
        w.slot_est = 1'b1;
      end
      UPC_S_KQ: begin
        w.op      = LOP_KQ;
        w.b_en    = 1'b1;
        w.slot_rd = 1'b1;
      end
      UPC_S_FIX: begin
        w.op   = LOP_FIX;
        w.b_en = 1'b1;
      end
      UPC_S_MR: begin
        w.op   = LOP_MR;
        w.b_en = 1'b1;
      end
      UPC_S_KR: begin
        w.op   = LOP_KR;
        w.b_en = 1'b1;
      end
      UPC_S_FIN: begin
        w.op   = LOP_FIN;
        w.b_en = 1'b1;
      end
      UPC_EMIT: begin
        w.emit = 1'b1;
        w.jmp  = JMP_END;
      end
      default: w.jmp = JMP_END;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/clsr_lane.sv =====
// ---------------------------------------------------------------------------
// clsr_lane
// One multiplicative generator stepped by Schrage factorization, one phase
// per control word.
// ---------------------------------------------------------------------------
`default_nettype none

module clsr_lane (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire clsr_pkg::lop_t      op,
  input  wire logic                ld,
  input  wire logic [30:0]         ld_val,
  input  wire clsr_pkg::lane_cst_t cst,
  output logic [30:0]              z
);
  import clsr_pkg::*;

  logic [30:0] z_r, z_nxt;
  logic [62:0] p_r, p_nxt;
  logic [15:0] k_r, k_nxt;
  logic [15:0] r_r, r_nxt;
  logic [29:0] q_r, q_nxt;

  logic [62:0] zr_prod;
  logic [31:0] kq_prod;
  logic [31:0] fix_diff;
  logic [31:0] mr_prod;
  logic [29:0] kr_prod;
  logic [32:0] fin_diff;

  assign zr_prod  = z_r * cst.recip;
  assign kq_prod  = p_r[62:47] * cst.quo;
  assign fix_diff = {1'b0, z_r} - p_r[31:0];
  assign mr_prod  = cst.mul * r_r;
  assign kr_prod  = k_r * cst.rem;
  assign fin_diff = {1'b0, p_r[31:0]} - {3'b000, q_r};

  always_comb begin
    z_nxt = z_r;
    p_nxt = p_r;
    k_nxt = k_r;
    r_nxt = r_r;
    q_nxt = q_r;
    if (ld) begin
      z_nxt = ld_val;
    end else begin
      case (op)
        LOP_RECIP: p_nxt = zr_prod;
        LOP_KQ: begin
          k_nxt = p_r[62:47];
          p_nxt = {31'd0, kq_prod};
        end
        LOP_FIX: begin
          // the estimate is short by at most one quotient
          if (fix_diff >= {16'd0, cst.quo}) begin
            k_nxt = k_r + 16'd1;
            r_nxt = 16'(fix_diff - {16'd0, cst.quo});
          end else begin
            r_nxt = 16'(fix_diff);
          end
        end
        LOP_MR:  p_nxt = {31'd0, mr_prod};
        LOP_KR:  q_nxt = kr_prod;
        LOP_FIN: begin
          if (fin_diff[32]) begin
            z_nxt = 31'(fin_diff + {2'b00, cst.modulus});
          end else begin
            z_nxt = fin_diff[30:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z_r <= cst.init;
    end else begin
      z_r <= z_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    k_r <= k_nxt;
    r_r <= r_nxt;
    q_r <= q_nxt;
  end

  assign z = z_r;

endmodule

`default_nettype wire

// ===== rtl/clsr_useq.sv =====
// ---------------------------------------------------------------------------
// clsr_useq
// Microprogram sequencer: step counter, warm-up loop counter and jumps.
// ---------------------------------------------------------------------------
`default_nettype none

module clsr_useq #(
  parameter int TABLE_DEPTH = 32,
  parameter int JW          = $clog2(TABLE_DEPTH + clsr_pkg::WARMUP_EXTRA)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          cmd,
  input  wire logic          out_stall,
  output logic               busy,
  output clsr_pkg::ctl_t     ctl,
  output logic [JW-1:0]      warm_idx
);
  import clsr_pkg::*;

  localparam logic [JW-1:0] WARM_LAST = JW'(TABLE_DEPTH + WARMUP_EXTRA - 1);

  logic          busy_r, busy_nxt;
  upc_t          pc_r, pc_nxt;
  logic [JW-1:0] j_r, j_nxt;
  logic          cmd_r, cmd_nxt;
  ucw_t          uw;
  logic          stall;

  assign uw    = clsr_ucode(pc_r);
  assign stall = uw.emit && out_stall;

  // next step
  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    j_nxt    = j_r;
    cmd_nxt  = cmd_r;
    if (start) begin
      busy_nxt = 1'b1;
      pc_nxt   = UPC_DISPATCH;
      cmd_nxt  = cmd;
    end else if (busy_r && !stall) begin
      case (uw.jmp)
        JMP_NEXT: pc_nxt = pc_r + 4'd1;
        JMP_CMD: begin
          if (cmd_r) begin
            pc_nxt = uw.target;
            j_nxt  = WARM_LAST;
          end else begin
            pc_nxt = UPC_S_RECIP;
          end
        end
        JMP_LOOP: begin
          if (j_r != '0) begin
            j_nxt  = j_r - JW'(1);
            pc_nxt = uw.target;
          end else begin
            pc_nxt = pc_r + 4'd1;
          end
        end
        JMP_END: begin
          busy_nxt = 1'b0;
          pc_nxt   = UPC_DISPATCH;
        end
        default: begin
          busy_nxt = 1'b0;
          pc_nxt   = UPC_DISPATCH;
        end
      endcase
    end
  end

  // control outputs, quiet while idle
  always_comb begin
    ctl.a_op     = busy_r ? uw.op : LOP_NONE;
    ctl.b_op     = (busy_r && uw.b_en) ? uw.op : LOP_NONE;
    ctl.seed_ld  = busy_r && uw.seed_ld && cmd_r;
    ctl.warm_wr  = busy_r && uw.warm_wr;
    ctl.slot_est = busy_r && uw.slot_est;
    ctl.slot_rd  = busy_r && uw.slot_rd;
    ctl.emit     = busy_r && uw.emit && !out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= UPC_DISPATCH;
      j_r    <= '0;
      cmd_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
      j_r    <= j_nxt;
      cmd_r  <= cmd_nxt;
    end
  end

  assign busy     = busy_r;
  assign warm_idx = j_r;

endmodule

`default_nettype wire

// ===== rtl/clsr_shuf.sv =====
// ---------------------------------------------------------------------------
// clsr_shuf
// Shuffle table with valid bits, slot selection from the last output and the
// final combination of the two generators.
// ---------------------------------------------------------------------------
`default_nettype none

module clsr_shuf #(
  parameter int TABLE_DEPTH = 32,
  parameter int JW          = $clog2(TABLE_DEPTH + clsr_pkg::WARMUP_EXTRA)
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire clsr_pkg::ctl_t ctl,
  input  wire logic [JW-1:0]  warm_idx,
  input  wire logic [30:0]    z_a,
  input  wire logic [30:0]    z_b,
  output logic [30:0]         y
);
  import clsr_pkg::*;

  localparam int          IW        = $clog2(TABLE_DEPTH);
  localparam logic [63:0] SLOT_DIV  = 64'd1 + (64'(MOD_A) - 64'd1) / 64'(TABLE_DEPTH);
  localparam logic [63:0] SLOT_R64  = (64'd1 << 32) / SLOT_DIV;
  localparam int          RW        = $clog2(SLOT_R64 + 64'd1);
  localparam int          EW        = RW - 1;
  localparam logic [RW-1:0] SLOT_REC = RW'(SLOT_R64);
  localparam logic [30:0] DIV31     = SLOT_DIV[30:0];
  localparam logic [EW:0] SLOT_MAX  = (EW + 1)'(TABLE_DEPTH - 1);

  logic [30:0]            mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld_r;
  logic [30:0]            rd_r;
  logic                   rd_ok_r;
  logic [30:0]            last_r, last_nxt;
  logic [EW-1:0]          est_r;
  logic [IW-1:0]          slot_r, slot_nxt;

  logic [30+RW:0]         sprod;
  logic [EW:0]            est1;
  logic [EW+31:0]         lim;
  logic [EW:0]            slot_full;
  logic                   warm_hit;
  logic                   wr_en;
  logic [IW-1:0]          wr_addr;
  logic [30:0]            rd_val;
  logic [32:0]            y_raw;

  // slot = last / SLOT_DIV, estimated by reciprocal and corrected by one
  assign sprod = last_r * SLOT_REC;
  assign est1  = {1'b0, est_r} + (EW + 1)'(1);
  assign lim   = est1 * DIV31;

  always_comb begin
    if ((EW + 32)'(last_r) >= lim) begin
      slot_full = est1;
    end else begin
      slot_full = {1'b0, est_r};
    end
    if (slot_full > SLOT_MAX) begin
      slot_nxt = IW'(SLOT_MAX);
    end else begin
      slot_nxt = IW'(slot_full);
    end
  end

  assign warm_hit = ctl.warm_wr && (warm_idx < JW'(TABLE_DEPTH));
  assign wr_en    = warm_hit || ctl.emit;
  assign wr_addr  = ctl.emit ? slot_r : IW'(warm_idx);

  // never-written entries read as zero
  assign rd_val = rd_ok_r ? rd_r : 31'd0;
  assign y_raw  = {2'b00, rd_val} - {2'b00, z_b};

  always_comb begin
    if (y_raw[32] || (y_raw == 33'd0)) begin
      y = 31'(y_raw + 33'(MOD_A) - 33'd1);
    end else begin
      y = y_raw[30:0];
    end
  end

  always_comb begin
    last_nxt = last_r;
    if (ctl.emit) begin
      last_nxt = y;
    end else if (ctl.warm_wr && (warm_idx == '0)) begin
      last_nxt = z_a;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= z_a;
    end
    if (ctl.slot_rd) begin
      rd_r <= mem[slot_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      rd_ok_r <= 1'b0;
      last_r  <= '0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (ctl.slot_rd) begin
        rd_ok_r <= vld_r[slot_nxt];
      end
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.slot_est) begin
      est_r <= sprod[30+RW:32];
    end
    if (ctl.slot_rd) begin
      slot_r <= slot_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/combined_lcg_shuffle_rng_unit.sv =====
// ---------------------------------------------------------------------------
// combined_lcg_shuffle_rng_unit
// Combined two-generator LCG with a Bays-Durham shuffle table, run by a
// microprogrammed sequencer over two Schrage datapath lanes.
// ---------------------------------------------------------------------------
//
//  Channel | Direction | tdata                  | tuser    | Transaction
//  --------+-----------+------------------------+----------+-----------------------
//  in_     | slave     | seed_value [30:0]      | command  | one command
//  out_    | master    | random_value [30:0]    | -        | one number per command
//
//  Next command: dispatch, the output sequence and emit run from acceptance until
//  the result shows and in_tready returns. Reseed adds a warm-up loop of
//  TABLE_DEPTH + 8 generator steps. Each generator step is six dependent microcode
//  steps in a lane, one Schrage phase per step; the warm-up loop runs generator
//  one alone, one step per pass.
//  Reset is synchronous; table entries carry valid bits, so no clearing pass.
//  A waiting result does not block a new input; a held output stalls the
//  sequencer at its final step only.
//
`default_nettype none

module combined_lcg_shuffle_rng_unit #(
  parameter int TABLE_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [30:0] seed_value, [31] zero fill
  input  wire logic        in_tuser,   // [0] command: 0 next, 1 reseed
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // [30:0] random_value, [31] zero fill
);
  import clsr_pkg::*;

  localparam int JW = $clog2(TABLE_DEPTH + WARMUP_EXTRA);

  logic          busy;
  ctl_t          ctl;
  logic [JW-1:0] warm_idx;
  logic          in_fire;
  logic          out_stall;
  logic [30:0]   seed_r, seed_nxt;
  logic [30:0]   seed_ld_val;
  logic [30:0]   z_a, z_b;
  logic [30:0]   y;
  logic          out_valid_r, out_valid_nxt;
  logic [30:0]   out_data_r, out_data_nxt;

  // accept a new transaction whenever the sequencer is free
  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;
  assign out_stall = out_valid_r && !out_tready;

  // hold the seed for the dispatch step; zero becomes one
  assign seed_nxt    = in_fire ? in_tdata[30:0] : seed_r;
  assign seed_ld_val = (seed_r == 31'd0) ? 31'd1 : seed_r;

  clsr_useq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .JW          (JW)
  ) u_useq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_fire),
    .cmd       (in_tuser),
    .out_stall (out_stall),
    .busy      (busy),
    .ctl       (ctl),
    .warm_idx  (warm_idx)
  );

  // generator one: modulus 2147483563
  clsr_lane u_lane_a (
    .clk    (clk),
    .rst_n  (rst_n),
    .op     (ctl.a_op),
    .ld     (ctl.seed_ld),
    .ld_val (seed_ld_val),
    .cst    (LANE_A_CST),
    .z      (z_a)
  );

  // generator two: modulus 2147483399, copies the seed on a reseed
  clsr_lane u_lane_b (
    .clk    (clk),
    .rst_n  (rst_n),
    .op     (ctl.b_op),
    .ld     (ctl.seed_ld),
    .ld_val (seed_ld_val),
    .cst    (LANE_B_CST),
    .z      (z_b)
  );

  clsr_shuf #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .JW          (JW)
  ) u_shuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .warm_idx (warm_idx),
    .z_a      (z_a),
    .z_b      (z_b),
    .y        (y)
  );

  // output register: load on emit, drop once the consumer takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (ctl.emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = y;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    seed_r     <= seed_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};

endmodule

`default_nettype wire

// ===== rtl/clsr_chk.sv =====
// ---------------------------------------------------------------------------
// clsr_chk
// Port-level checks of the combined LCG shuffle RNG, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "combined_lcg_shuffle_rng_unit_assert.svh"

module clsr_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);
  import clsr_pkg::*;

  logic out_in_range;
  logic out_stalled;

  assign out_in_range = (out_tdata != 32'd0) && (out_tdata < {1'b0, MOD_A});
  assign out_stalled  = out_tvalid && !out_tready;

  // one command at a time: ready drops after a transaction
  `CLSR_ASSERT_NEXT(a_in_one_at_a_time, in_tvalid && in_tready, !in_tready, "second input taken")

  // every number lies in 1 .. MOD_A - 1, top bit clear
  `CLSR_ASSERT_SAME(a_out_range, out_tvalid, out_in_range, "result out of range")

  // a new result appears only at the end of a command in work
  `CLSR_ASSERT_SAME(a_out_from_work, $rose(out_tvalid), $past(!in_tready), "unrequested result")

  // a stalled result holds
  `CLSR_ASSERT_NEXT(a_out_hold, out_stalled, out_tvalid && $stable(out_tdata), "result changed")

endmodule

bind combined_lcg_shuffle_rng_unit clsr_chk u_clsr_chk (.*);

`default_nettype wire
